// ===== design/assert_macros.svh =====
// Assertion macros shared by the LCA unit RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TLCA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tlca assertion failed");

// next-cycle implication
`define TLCA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tlca assertion failed");

`endif

// ===== design/tlca_pkg.sv =====
// Shared types, codes and sizes of the LCA unit.
// No dependencies; used by tlca_engine and tree_lca_binary_lifting_unit.
`default_nettype none

package tlca_pkg;

  localparam int NODES   = 1024;
  localparam int NODE_W  = 10;
  localparam int LEVELS  = 10;
  localparam int LVL_W   = 4;
  localparam int JADDR_W = NODE_W + LVL_W;
  localparam int JDEPTH  = NODES << LVL_W;
  localparam int TDATA_W = 24;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [JADDR_W-1:0] jaddr_t;
  typedef logic [1:0]         cmd_t;
  typedef logic [1:0]         status_t;

  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_QUERY = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  localparam status_t ST_LOAD  = 2'd0;
  localparam status_t ST_QUERY = 2'd1;
  localparam status_t ST_CLEAR = 2'd2;
  localparam status_t ST_ERROR = 2'd3;

  localparam lvl_t LVL_TOP = lvl_t'(LEVELS - 1);

  // depth store port: one write, two reads
  typedef struct packed {
    logic  we;
    node_t waddr;
    node_t wdata;
    node_t raddr0;
    node_t raddr1;
  } node_req_t;

  typedef struct packed {
    logic   we;
    jaddr_t waddr;
    node_t  wdata;
    jaddr_t raddr0;
    jaddr_t raddr1;
  } jump_req_t;

  typedef struct packed {
    logic  we;
    node_t waddr;
    logic  wdata;
    node_t raddr0;
    node_t raddr1;
  } flag_req_t;

  typedef struct packed {
    status_t status;
    node_t   ancestor;
    node_t   depth;
  } result_t;

  function automatic jaddr_t jaddr(input node_t n, input lvl_t k);
    return {n, k};
  endfunction

endpackage

`default_nettype wire

// ===== design/tlca_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
`default_nettype none

module tlca_ram #(
  parameter int W     = 10,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr0,
  input  wire logic [AW-1:0] raddr1,
  output logic      [W-1:0]  rdata0,
  output logic      [W-1:0]  rdata1
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata0_r;
  logic [W-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

`default_nettype wire

// ===== design/tlca_engine.sv =====
// Sequencer of the LCA unit: flag sweep, load, lift and meet phases.
// Depends on tlca_pkg and assert_macros.svh; drives the three RAMs.
`default_nettype none
`include "assert_macros.svh"

module tlca_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tlca_pkg::cmd_t     in_cmd,
  input  wire tlca_pkg::node_t    in_a,
  input  wire tlca_pkg::node_t    in_b,
  output tlca_pkg::node_req_t     dreq,
  input  wire tlca_pkg::node_t    d_rd0,
  input  wire tlca_pkg::node_t    d_rd1,
  output tlca_pkg::jump_req_t     jreq,
  input  wire tlca_pkg::node_t    j_rd0,
  input  wire tlca_pkg::node_t    j_rd1,
  output tlca_pkg::flag_req_t     freq,
  input  wire logic               f_rd0,
  input  wire logic               f_rd1,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output tlca_pkg::result_t       res
);

  localparam logic [3:0] S_SWEEP = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_UP    = 4'd4;
  localparam logic [3:0] S_UPEND = 4'd5;
  localparam logic [3:0] S_MEET  = 4'd6;
  localparam logic [3:0] S_LAST  = 4'd7;
  localparam logic [3:0] S_ANS   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam tlca_pkg::status_t ST_LOAD_V  = tlca_pkg::ST_LOAD;
  localparam tlca_pkg::status_t ST_QUERY_V = tlca_pkg::ST_QUERY;
  localparam tlca_pkg::status_t ST_CLEAR_V = tlca_pkg::ST_CLEAR;
  localparam tlca_pkg::status_t ST_ERROR_V = tlca_pkg::ST_ERROR;

  logic [3:0]        state_r, state_nxt;
  tlca_pkg::node_t   sw_r, sw_nxt;
  logic              clr_resp_r, clr_resp_nxt;
  logic              pend_r, pend_nxt;

  tlca_pkg::cmd_t    cmd_r, cmd_nxt;
  tlca_pkg::node_t   a_r, a_nxt;
  tlca_pkg::node_t   b_r, b_nxt;
  tlca_pkg::node_t   lo_r, lo_nxt;
  tlca_pkg::node_t   hi_r, hi_nxt;
  tlca_pkg::node_t   dlo_r, dlo_nxt;
  tlca_pkg::node_t   diff_r, diff_nxt;
  tlca_pkg::lvl_t    k_r, k_nxt;
  tlca_pkg::lvl_t    pk_r, pk_nxt;
  logic              z0_r, z0_nxt;
  logic              z1_r, z1_nxt;
  tlca_pkg::result_t res_r, res_nxt;

  logic              accept;
  tlca_pkg::node_t   j0, j1;
  tlca_pkg::node_t   da, db;
  logic              fa, fb;
  logic              swap;
  tlca_pkg::node_t   up_cur;
  logic              differ;
  tlca_pkg::node_t   lo_cur, hi_cur, dlo_cur;

  // the sentinel row reads as zero whatever the RAM holds
  assign j0 = z0_r ? '0 : j_rd0;
  assign j1 = z1_r ? '0 : j_rd1;

  assign fa   = (a_r == '0) | f_rd0;
  assign fb   = (b_r == '0) | f_rd1;
  assign da   = (a_r == '0) ? '0 : d_rd0;
  assign db   = (b_r == '0) ? '0 : d_rd1;
  assign swap = da > db;

  assign up_cur  = pend_r ? j0 : hi_r;
  assign differ  = pend_r && (j0 != j1);
  assign lo_cur  = differ ? j0 : lo_r;
  assign hi_cur  = differ ? j1 : hi_r;
  assign dlo_cur = differ ? dlo_r - (tlca_pkg::node_t'(1) << pk_r) : dlo_r;

  assign in_ready  = state_r == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign res_valid = state_r == S_DONE;
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    sw_nxt       = sw_r;
    clr_resp_nxt = clr_resp_r;
    pend_nxt     = pend_r;
    cmd_nxt      = cmd_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    dlo_nxt      = dlo_r;
    diff_nxt     = diff_r;
    k_nxt        = k_r;
    pk_nxt       = pk_r;
    z0_nxt       = z0_r;
    z1_nxt       = z1_r;
    res_nxt      = res_r;

    dreq = '{we: 1'b0, waddr: a_r, wdata: db + 1'b1, raddr0: in_a, raddr1: in_b};
    jreq = '{we: 1'b0, waddr: tlca_pkg::jaddr(a_r, k_r), wdata: j0,
             raddr0: '0, raddr1: '0};
    freq = '{we: 1'b0, waddr: a_r, wdata: 1'b1, raddr0: in_a, raddr1: in_b};

    unique case (state_r)
      S_SWEEP: begin
        freq.we    = 1'b1;
        freq.waddr = sw_r;
        freq.wdata = 1'b0;
        sw_nxt     = sw_r + 1'b1;
        if (sw_r == '1) begin
          clr_resp_nxt = 1'b0;
          if (clr_resp_r) begin
            res_nxt   = '{ST_CLEAR_V, '0, '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_cmd;
          a_nxt   = in_a;
          b_nxt   = in_b;
          priority if (in_cmd == tlca_pkg::CMD_CLEAR) begin
            sw_nxt       = '0;
            clr_resp_nxt = 1'b1;
            state_nxt    = S_SWEEP;
          end else if (in_cmd == tlca_pkg::CMD_LOAD || in_cmd == tlca_pkg::CMD_QUERY) begin
            state_nxt = S_CHECK;
          end else begin
            res_nxt   = '{ST_ERROR_V, '0, '0};
            state_nxt = S_DONE;
          end
        end
      end
      S_CHECK: begin
        if (cmd_r == tlca_pkg::CMD_LOAD) begin
          if (a_r == '0 || fa || !fb) begin
            res_nxt   = '{ST_ERROR_V, '0, '0};
            state_nxt = S_DONE;
          end else begin
            dreq.we     = 1'b1;
            jreq.we     = 1'b1;
            jreq.waddr  = tlca_pkg::jaddr(a_r, '0);
            jreq.wdata  = b_r;
            freq.we     = 1'b1;
            jreq.raddr0 = tlca_pkg::jaddr(b_r, '0);
            z0_nxt      = b_r == '0;
            k_nxt       = tlca_pkg::lvl_t'(1);
            state_nxt   = S_LOAD;
          end
        end else begin
          if (!fa || !fb) begin
            res_nxt   = '{ST_ERROR_V, '0, '0};
            state_nxt = S_DONE;
          end else begin
            lo_nxt    = swap ? b_r : a_r;
            hi_nxt    = swap ? a_r : b_r;
            dlo_nxt   = swap ? db : da;
            diff_nxt  = swap ? da - db : db - da;
            k_nxt     = tlca_pkg::LVL_TOP;
            pend_nxt  = 1'b0;
            state_nxt = S_UP;
          end
        end
      end
      S_LOAD: begin
        // jump[a][k] = jump[jump[a][k-1]][k-1], then fetch its row at level k
        jreq.we     = 1'b1;
        jreq.raddr0 = tlca_pkg::jaddr(j0, k_r);
        z0_nxt      = j0 == '0;
        if (k_r == tlca_pkg::LVL_TOP) begin
          res_nxt   = '{ST_LOAD_V, '0, '0};
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_UP: begin
        hi_nxt = up_cur;
        if (diff_r[k_r]) begin
          jreq.raddr0 = tlca_pkg::jaddr(up_cur, k_r);
          z0_nxt      = up_cur == '0;
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (k_r == '0) begin
          state_nxt = S_UPEND;
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end
      S_UPEND: begin
        hi_nxt   = up_cur;
        pend_nxt = 1'b0;
        if (lo_r == up_cur) begin
          res_nxt   = '{ST_QUERY_V, lo_r, dlo_r};
          state_nxt = S_DONE;
        end else begin
          k_nxt     = tlca_pkg::LVL_TOP;
          state_nxt = S_MEET;
        end
      end
      S_MEET: begin
        lo_nxt      = lo_cur;
        hi_nxt      = hi_cur;
        dlo_nxt     = dlo_cur;
        jreq.raddr0 = tlca_pkg::jaddr(lo_cur, k_r);
        jreq.raddr1 = tlca_pkg::jaddr(hi_cur, k_r);
        z0_nxt      = lo_cur == '0;
        z1_nxt      = hi_cur == '0;
        pend_nxt    = 1'b1;
        pk_nxt      = k_r;
        if (k_r == '0) begin
          state_nxt = S_LAST;
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end
      S_LAST: begin
        lo_nxt      = lo_cur;
        hi_nxt      = hi_cur;
        dlo_nxt     = dlo_cur;
        jreq.raddr0 = tlca_pkg::jaddr(lo_cur, '0);
        z0_nxt      = lo_cur == '0;
        pend_nxt    = 1'b0;
        state_nxt   = S_ANS;
      end
      S_ANS: begin
        res_nxt   = '{ST_QUERY_V, j0, dlo_r - 1'b1};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_SWEEP;
        sw_nxt    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      sw_r       <= '0;
      clr_resp_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sw_r       <= sw_nxt;
      clr_resp_r <= clr_resp_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    dlo_r  <= dlo_nxt;
    diff_r <= diff_nxt;
    k_r    <= k_nxt;
    pk_r   <= pk_nxt;
    z0_r   <= z0_nxt;
    z1_r   <= z1_nxt;
    res_r  <= res_nxt;
  end

  `TLCA_ASSERT_IMP(a_sweep_blocks_input, clk, rst_n, state_r == S_SWEEP, !in_ready)
  `TLCA_ASSERT_IMP(a_jump_write_own_row, clk, rst_n, jreq.we, jreq.waddr[tlca_pkg::JADDR_W-1:tlca_pkg::LVL_W] == a_r)
  `TLCA_ASSERT_IMP(a_non_query_zero, clk, rst_n, res_valid && res_r.status != tlca_pkg::ST_QUERY, res_r.ancestor == '0 && res_r.depth == '0)
  `TLCA_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, accept, state_r != S_IDLE)

endmodule

`default_nettype wire

// ===== design/tree_lca_binary_lifting_unit.sv =====
// Top level of the LCA unit: stream ports, RAMs and output register.
// Depends on tlca_pkg, tlca_ram, tlca_engine and assert_macros.svh.
//
//   channel | dir | payload (low bit up)
//   in_     | in  | cmd, node_a, node_b
//   out_    | out | status, ancestor, ancestor_depth
//
// Load and query times are set by the walk over the jump-table RAM, one level a
// cycle; an error result is given before any walk.
// Clear and reset run a sweep over all 1024 flags, one a cycle, with
// the input stalled; the clear result follows the sweep.
// One item at a time; a finished result waits in the output register while
// the next item is taken.
`default_nettype none
`include "assert_macros.svh"

module tree_lca_binary_lifting_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [tlca_pkg::TDATA_W-1:0]   in_tdata,   // cmd, node_a, node_b
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [tlca_pkg::TDATA_W-1:0]   out_tdata   // status, ancestor, ancestor_depth
);

  tlca_pkg::node_req_t dreq;
  tlca_pkg::jump_req_t jreq;
  tlca_pkg::flag_req_t freq;
  tlca_pkg::node_t     d_rd0, d_rd1, j_rd0, j_rd1;
  logic                f_rd0, f_rd1;
  logic                res_valid, res_ready;
  tlca_pkg::result_t   res;

  logic                out_tvalid_r;
  tlca_pkg::result_t   out_data_r;

  tlca_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tdata[1:0]),
    .in_a      (in_tdata[11:2]),
    .in_b      (in_tdata[21:12]),
    .dreq      (dreq),
    .d_rd0     (d_rd0),
    .d_rd1     (d_rd1),
    .jreq      (jreq),
    .j_rd0     (j_rd0),
    .j_rd1     (j_rd1),
    .freq      (freq),
    .f_rd0     (f_rd0),
    .f_rd1     (f_rd1),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  tlca_ram #(.W(tlca_pkg::NODE_W), .DEPTH(tlca_pkg::NODES), .AW(tlca_pkg::NODE_W)) u_depth (
    .clk    (clk),
    .we     (dreq.we),
    .waddr  (dreq.waddr),
    .wdata  (dreq.wdata),
    .raddr0 (dreq.raddr0),
    .raddr1 (dreq.raddr1),
    .rdata0 (d_rd0),
    .rdata1 (d_rd1)
  );

  tlca_ram #(.W(tlca_pkg::NODE_W), .DEPTH(tlca_pkg::JDEPTH), .AW(tlca_pkg::JADDR_W)) u_jump (
    .clk    (clk),
    .we     (jreq.we),
    .waddr  (jreq.waddr),
    .wdata  (jreq.wdata),
    .raddr0 (jreq.raddr0),
    .raddr1 (jreq.raddr1),
    .rdata0 (j_rd0),
    .rdata1 (j_rd1)
  );

  tlca_ram #(.W(1), .DEPTH(tlca_pkg::NODES), .AW(tlca_pkg::NODE_W)) u_flags (
    .clk    (clk),
    .we     (freq.we),
    .waddr  (freq.waddr),
    .wdata  (freq.wdata),
    .raddr0 (freq.raddr0),
    .raddr1 (freq.raddr1),
    .rdata0 (f_rd0),
    .rdata1 (f_rd1)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_data_r.depth, out_data_r.ancestor, out_data_r.status};

  `TLCA_ASSERT_NXT(a_result_lands, clk, rst_n, res_valid && res_ready, out_tvalid_r)

endmodule

`default_nettype wire
